// ----- hdl/arpr_pkg.sv -----
// Shared constants, types and byte-select helpers for the ARP request responder.
`default_nettype none
package arpr_pkg;

    // Frame geometry (byte indexes within the frame)
    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] FRAME_LEN = 6'd42;
    localparam logic [POS_W-1:0] LAST_IDX  = 6'd41;
    localparam logic [POS_W-1:0] HDR_START = 6'd14;
    localparam logic [POS_W-1:0] SMAC_START = 6'd22;
    localparam logic [POS_W-1:0] SIP_START = 6'd28;
    localparam logic [POS_W-1:0] TMAC_START = 6'd32;
    localparam logic [POS_W-1:0] TIP_START = 6'd38;
    localparam logic [POS_W-1:0] OPER_START = 6'd20;
    localparam logic [POS_W-1:0] ETYPE_START = 6'd12;
    localparam logic [POS_W-1:0] OMAC_START = 6'd6;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] OPER_REPLY    = 16'h0002;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd1;

    // Reply request from the parser to the transmitter
    typedef struct packed {
        logic        start;
        logic [47:0] mac;
        logic [31:0] ip;
    } start_t;

    // Transmitter status
    typedef struct packed {
        logic busy;
    } tx_stat_t;

    // Expected ARP header bytes 14..21 of a request
    function automatic logic [7:0] hdr_byte(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = 8'h00;
            3'd1:    b = 8'h01;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h04;
            3'd6:    b = 8'h00;
            3'd7:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte k of a MAC address, wire order
    function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = m[47:40];
            3'd1:    b = m[39:32];
            3'd2:    b = m[31:24];
            3'd3:    b = m[23:16];
            3'd4:    b = m[15:8];
            3'd5:    b = m[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte k of an IPv4 address, wire order
    function automatic logic [7:0] ip_byte(input logic [31:0] a, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = a[31:24];
            2'd1:    b = a[23:16];
            2'd2:    b = a[15:8];
            2'd3:    b = a[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/arpr_rx_if.sv -----
// Receive byte channel: valid/ready handshake with one frame byte per word.
`default_nettype none
interface arpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/arpr_tx_if.sv -----
// Transmit byte channel: valid/ready handshake with one reply byte per word.
`default_nettype none
interface arpr_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;

    modport source (output valid, output tx_byte, output tx_last, input ready);
    modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/arpr_parse.sv -----
// Receive parser: tracks byte position, checks the ARP request header, captures the sender.
`default_nettype none
module arpr_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc,
    input  logic [7:0]           rx_byte,
    input  logic                 rx_last,
    input  logic [31:0]          own_ip,
    output arpr_pkg::start_t     start
);
    import arpr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_inc, rel_hdr, rel_tip;
    logic             good_reg, good_next, good_upd, fail;
    logic [47:0]      mac_reg, mac_next;
    logic [31:0]      ip_reg, ip_next;

    // Check or capture the current word by its position
    always_comb
    begin
        fail     = 1'b0;
        mac_next = mac_reg;
        ip_next  = ip_reg;
        pos_inc  = pos_reg;
        rel_hdr  = pos_reg - HDR_START;
        rel_tip  = pos_reg - TIP_START;
        if (pos_reg < FRAME_LEN)
        begin
            pos_inc = pos_reg + 6'd1;
            if (pos_reg >= HDR_START && pos_reg < SMAC_START)
            begin
                fail = (rx_byte != hdr_byte(rel_hdr[2:0]));
            end
            else if (pos_reg >= SMAC_START && pos_reg < SIP_START)
            begin
                mac_next = {mac_reg[39:0], rx_byte};
            end
            else if (pos_reg >= SIP_START && pos_reg < TMAC_START)
            begin
                ip_next = {ip_reg[23:0], rx_byte};
            end
            else if (pos_reg >= TIP_START)
            begin
                fail = (rx_byte != ip_byte(own_ip, rel_tip[1:0]));
            end
        end
        good_upd = good_reg & ~fail;

        // Restart at the frame end, else advance
        if (acc && rx_last)
        begin
            pos_next  = '0;
            good_next = 1'b1;
        end
        else if (acc)
        begin
            pos_next  = pos_inc;
            good_next = good_upd;
        end
        else
        begin
            pos_next  = pos_reg;
            good_next = good_reg;
        end

        // Request a reply on the last byte of a full matching request
        start.start = acc & rx_last & good_upd & (pos_inc == FRAME_LEN);
        start.mac   = mac_reg;
        start.ip    = ip_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            good_reg <= 1'b1;
        end
        else
        begin
            pos_reg  <= pos_next;
            good_reg <= good_next;
        end
    end

    // Hold captured addresses unless a word is taken
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mac_reg <= mac_next;
            ip_reg  <= ip_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/arpr_tx.sv -----
// Reply transmitter: snapshots the requester, sequences 42 reply bytes into an output register.
`default_nettype none
module arpr_tx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arpr_pkg::start_t     start,
    input  logic [47:0]          own_mac,
    input  logic [31:0]          own_ip,
    arpr_tx_if.source            tx,
    output arpr_pkg::tx_stat_t   stat
);
    import arpr_pkg::*;

    logic             busy_reg, busy_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [47:0]      rmac_reg;
    logic [31:0]      rip_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             advance;
    logic [7:0]       rbyte;
    logic [POS_W-1:0] rel_omac, rel_hdr, rel_smac, rel_sip, rel_tmac, rel_tip;

    // Select the reply byte at the current index
    always_comb
    begin
        rel_omac = idx_reg - OMAC_START;
        rel_hdr  = idx_reg - HDR_START;
        rel_smac = idx_reg - SMAC_START;
        rel_sip  = idx_reg - SIP_START;
        rel_tmac = idx_reg - TMAC_START;
        rel_tip  = idx_reg - TIP_START;
        if (idx_reg < OMAC_START)
            rbyte = mac_byte(rmac_reg, idx_reg[2:0]);
        else if (idx_reg < ETYPE_START)
            rbyte = mac_byte(own_mac, rel_omac[2:0]);
        else if (idx_reg == ETYPE_START)
            rbyte = ETHERTYPE_ARP[15:8];
        else if (idx_reg < HDR_START)
            rbyte = ETHERTYPE_ARP[7:0];
        else if (idx_reg < OPER_START)
            rbyte = hdr_byte(rel_hdr[2:0]);
        else if (idx_reg == OPER_START)
            rbyte = OPER_REPLY[15:8];
        else if (idx_reg < SMAC_START)
            rbyte = OPER_REPLY[7:0];
        else if (idx_reg < SIP_START)
            rbyte = mac_byte(own_mac, rel_smac[2:0]);
        else if (idx_reg < TMAC_START)
            rbyte = ip_byte(own_ip, rel_sip[1:0]);
        else if (idx_reg < TIP_START)
            rbyte = mac_byte(rmac_reg, rel_tmac[2:0]);
        else
            rbyte = ip_byte(rip_reg, rel_tip[1:0]);
    end

    // Advance the sequencer when the output register is free
    always_comb
    begin
        advance        = busy_reg & (~out_valid_reg | tx.ready);
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (start.start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 6'd1;
            if (idx_reg == LAST_IDX)
                busy_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rbyte;
            out_last_next  = (idx_reg == LAST_IDX);
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the requester snapshot and output payload
    always_ff @(posedge clk)
    begin
        if (start.start)
        begin
            rmac_reg <= start.mac;
            rip_reg  <= start.ip;
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign tx.valid   = out_valid_reg;
    assign tx.tx_byte = out_byte_reg;
    assign tx.tx_last = out_last_reg;
    assign stat.busy  = busy_reg;

endmodule
`default_nettype wire

// ----- hdl/arp_request_responder.sv -----
// ARP request responder: parses received frames and emits 42-byte ARP replies for own IP.
// The receive side takes one frame byte per word, one word per cycle. From byte 14 it checks
// an ARP request header (htype 1, ptype 0x0800, hlen 6, plen 4, opcode 1) and a target IP equal
// to own_ip; the frame's ethertype is not checked. When the last byte of a matching request of
// at least 42 bytes is taken, a 42-word reply is sent from an output register, one per cycle
// while the sink is ready, with tx_last on the final word; it is addressed to the requester and
// carries own_mac/own_ip as sender. The sender addresses are snapshotted, so the next frame is
// received during a reply; only the last byte of a frame is held back (ready low) while a reply
// is still being sequenced, so only one reply is sequenced at a time. Write own_mac (index 0)
// and own_ip (index 1) through the cfg port only while the block is idle.
`default_nettype none
module arp_request_responder (
    input  logic                            clk,
    input  logic                            rst_n,
    arpr_rx_if.sink                         rx,
    arpr_tx_if.source                       tx,
    input  logic                            cfg_we,
    input  logic [arpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import arpr_pkg::*;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        rx_acc;
    start_t      start;
    tx_stat_t    tx_stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_MAC: own_mac_reg <= cfg_wdata[47:0];
                CFG_OWN_IP:  own_ip_reg  <= cfg_wdata[31:0];
                default:     ;
            endcase
        end
    end

    // Hold a frame's last byte while a reply is still sequencing
    assign rx.ready = ~(tx_stat.busy & rx.rx_last);
    assign rx_acc   = rx.valid & rx.ready;

    arpr_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (rx_acc),
        .rx_byte (rx.rx_byte),
        .rx_last (rx.rx_last),
        .own_ip  (own_ip_reg),
        .start   (start)
    );

    arpr_tx u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .own_mac (own_mac_reg),
        .own_ip  (own_ip_reg),
        .tx      (tx),
        .stat    (tx_stat)
    );

    // A reply starts only when the transmitter is idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start.start |-> !tx_stat.busy)
        else $error("reply started while transmitter busy");

    // A started reply keeps the transmitter busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start.start |=> tx_stat.busy)
        else $error("transmitter did not start");

    // A reply request needs an accepted last byte
    a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
        start.start |-> (rx_acc && rx.rx_last))
        else $error("reply request without frame end");

endmodule
`default_nettype wire

// ----- tb/tb_arp_request_responder.sv -----
// Self-checking testbench for the ARP request responder: frames in, reply words checked.
module tb_arp_request_responder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 130;
    localparam int DRAIN_CYCLES = 30;
    localparam int SETTLE_CYCLES = 8;

    // htype 1, ptype 0x0800, hlen 6, plen 4, opcode request, wire order
    localparam logic [63:0] ARP_REQ_HDR   = 64'h0001_0800_0604_0001;
    localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // Register indexes the block has no register behind
    localparam logic [arpr_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [arpr_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } reply_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [arpr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [arpr_pkg::CFG_DATA_W-1:0] cfg_wdata;

    arpr_rx_if rx_ch ();
    arpr_tx_if tx_ch ();

    arp_request_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .tx        (tx_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Responder state as the predictor tracks it
    logic [47:0] own_mac_q = '0;
    logic [31:0] own_ip_q  = '0;
    logic [5:0]  rx_pos    = '0;
    logic        hdr_ok    = 1'b1;
    logic [47:0] req_mac   = '0;
    logic [31:0] req_ip    = '0;

    reply_word_t reply_q[$];
    logic [7:0]  frame_q[$];

    int err_count   = 0;
    int cycle_count = 0;
    int idle_pct    = 16;
    int words_sent  = 0;

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL arp_request_responder");
            $finish;
        end
    end

    // Stall the reply side at random
    always @(posedge clk)
    begin
        tx_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Compare each reply word with the oldest expected word
    always @(posedge clk)
    begin
        reply_word_t exp_w;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (reply_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected reply word: expected none, actual byte %h last %b",
                         $time, tx_ch.tx_byte, tx_ch.tx_last);
            end
            else
            begin
                exp_w = reply_q.pop_front();
                if (tx_ch.tx_byte !== exp_w.data)
                begin
                    err_count++;
                    $display("%0t: tx_byte mismatch: expected %h actual %h",
                             $time, exp_w.data, tx_ch.tx_byte);
                end
                if (tx_ch.tx_last !== exp_w.is_last)
                begin
                    err_count++;
                    $display("%0t: tx_last mismatch: expected %b actual %b",
                             $time, exp_w.is_last, tx_ch.tx_last);
                end
            end
        end
    end

    // Advance the responder state by one received word; queue the reply it causes
    task automatic predict_word(input logic [7:0] data, input logic is_last);
        int          p;
        logic [335:0] reply;
        p = int'(rx_pos);
        if (p < int'(arpr_pkg::FRAME_LEN))
        begin
            if (p >= 14 && p < 22)
            begin
                if (data != ARP_REQ_HDR[8*(21-p) +: 8])
                    hdr_ok = 1'b0;
            end
            else if (p >= 22 && p < 28)
                req_mac = {req_mac[39:0], data};
            else if (p >= 28 && p < 32)
                req_ip = {req_ip[23:0], data};
            else if (p >= 38)
            begin
                if (data != own_ip_q[8*(41-p) +: 8])
                    hdr_ok = 1'b0;
            end
            p++;
        end
        if (is_last)
        begin
            if (p == int'(arpr_pkg::FRAME_LEN) && hdr_ok)
            begin
                reply = {req_mac, own_mac_q, arpr_pkg::ETHERTYPE_ARP, ARP_REQ_HDR[63:16],
                         arpr_pkg::OPER_REPLY, own_mac_q, own_ip_q, req_mac, req_ip};
                for (int i = 0; i < 42; i++)
                    reply_q.push_back('{data: reply[8*(41-i) +: 8], is_last: (i == 41)});
            end
            rx_pos = '0;
            hdr_ok = 1'b1;
        end
        else
            rx_pos = 6'(p);
    endtask

    // Send one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] data, input logic is_last);
        while ($urandom_range(99) < idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= data;
        rx_ch.rx_last <= is_last;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        predict_word(data, is_last);
        words_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_word(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Drop valid and hold until every reply word is in and the block has settled
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [arpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arpr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == arpr_pkg::CFG_OWN_MAC)
            own_mac_q = data[47:0];
        else if (idx == arpr_pkg::CFG_OWN_IP)
            own_ip_q = data[31:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[47:0];
    endfunction

    // Push the low n bytes of v, most significant first
    task automatic push_bytes(input logic [63:0] v, input int n);
        for (int k = 0; k < n; k++)
            frame_q.push_back(v[8*(n-1-k) +: 8]);
    endtask

    // Build a well-formed 42-byte ARP request in frame_q
    task automatic build_request(input logic [47:0] smac, input logic [31:0] sip,
                                 input logic [31:0] tip, input logic [15:0] etype);
        frame_q.delete();
        push_bytes(64'(BROADCAST_MAC), 6);
        push_bytes(64'(smac), 6);
        push_bytes(64'(etype), 2);
        push_bytes(ARP_REQ_HDR, 8);
        push_bytes(64'(smac), 6);
        push_bytes(64'(sip), 4);
        push_bytes(64'(rand48()), 6);
        push_bytes(64'(tip), 4);
    endtask

    task automatic trim_frame(input int len);
        while (frame_q.size() > len)
            void'(frame_q.pop_back());
    endtask

    task automatic pad_frame(input int extra);
        repeat (extra) frame_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic random_config();
        write_reg(arpr_pkg::CFG_OWN_MAC, rand48());
        write_reg(arpr_pkg::CFG_OWN_IP, rand48());
    endtask

    // Request to the reset addresses, all-ones requester
    task automatic test_default_addresses();
        build_request(BROADCAST_MAC, 32'hFFFF_FFFF, 32'h0, arpr_pkg::ETHERTYPE_ARP);
        send_frame();
        wait_idle();
    endtask

    // All-ones, all-zero and end-bit address patterns; spare indexes must not disturb anything
    task automatic test_extreme_addresses();
        write_reg(arpr_pkg::CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        write_reg(arpr_pkg::CFG_OWN_IP, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_SPARE_2, rand48());
        write_reg(CFG_SPARE_3, rand48());
        build_request(48'h0, 32'h0, 32'hFFFF_FFFF, 16'h0000);
        for (int k = 0; k < 6; k++)
            frame_q[k] = 8'h00;
        send_frame();
        wait_idle();
        write_reg(arpr_pkg::CFG_OWN_MAC, 48'h8000_0000_0001);
        write_reg(arpr_pkg::CFG_OWN_IP, 48'h0000_8000_0001);
        build_request(48'h7FFF_FFFF_FFFE, 32'h7FFF_FFFE, 32'h8000_0001, 16'hFFFF);
        send_frame();
        wait_idle();
    endtask

    // Corrupt each header byte and each target IP byte in turn; then a clean request
    task automatic test_bad_header();
        int bad_pos[$];
        random_config();
        for (int p = 14; p < 22; p++)
            bad_pos.push_back(p);
        for (int p = 38; p < 42; p++)
            bad_pos.push_back(p);
        foreach (bad_pos[i])
        begin
            build_request(rand48(), $urandom(), own_ip_q, arpr_pkg::ETHERTYPE_ARP);
            frame_q[bad_pos[i]] ^= 8'($urandom_range(1, 255));
            send_frame();
        end
        build_request(rand48(), $urandom(), own_ip_q, arpr_pkg::ETHERTYPE_ARP);
        send_frame();
        wait_idle();
    endtask

    // Short frames get no reply; long frames reply and ignore the tail
    task automatic test_frame_length();
        int lens[$] = '{1, 22, 41, 42, 70, 41, 42};
        random_config();
        foreach (lens[i])
        begin
            build_request(rand48(), $urandom(), own_ip_q, 16'($urandom_range(16'hFFFF)));
            if (lens[i] < 42)
                trim_frame(lens[i]);
            else
                pad_frame(lens[i] - 42);
            send_frame();
        end
        wait_idle();
    endtask

    // Frames back to back with no idling on either side
    task automatic test_back_to_back();
        random_config();
        idle_pct = 0;
        for (int n = 0; n < 5; n++)
        begin
            build_request(rand48(), $urandom(), own_ip_q, arpr_pkg::ETHERTYPE_ARP);
            if (n == 2)
                trim_frame(30);
            else
                pad_frame($urandom_range(3));
            send_frame();
        end
        wait_idle();
        idle_pct = 16;
    endtask

    // Mostly good requests with random content, plus broken and noise frames
    task automatic test_random_traffic();
        int kind;
        int frame_cnt;
        frame_cnt  = 0;
        words_sent = 0;
        random_config();
        while (words_sent < RANDOM_WORDS)
        begin
            if (frame_cnt > 0 && frame_cnt % 4 == 0)
            begin
                wait_idle();
                random_config();
            end
            kind = $urandom_range(99);
            build_request(rand48(), $urandom(), own_ip_q,
                          ($urandom_range(3) == 0) ? 16'($urandom()) : arpr_pkg::ETHERTYPE_ARP);
            if (kind < 65)
            begin
                if ($urandom_range(3) == 0)
                    pad_frame($urandom_range(1, 24));
            end
            else if (kind < 75)
            begin
                for (int k = 38; k < 42; k++)
                    frame_q[k] ^= 8'($urandom_range(255));
            end
            else if (kind < 85)
                frame_q[$urandom_range(14, 21)] ^= 8'($urandom_range(1, 255));
            else if (kind < 92)
                trim_frame($urandom_range(1, 41));
            else
            begin
                frame_q.delete();
                pad_frame($urandom_range(1, 60));
            end
            send_frame();
            frame_cnt++;
        end
        wait_idle();
    endtask

    // Reset, run each test, then drain and report
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        rx_ch.rx_last = 1'b0;
        tx_ch.ready   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_addresses();
        test_extreme_addresses();
        test_bad_header();
        test_frame_length();
        test_back_to_back();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && reply_q.size() == 0)
            $display("PASS arp_request_responder");
        else
            $display("FAIL arp_request_responder");
        $finish;
    end

endmodule
